FILE: rtl/quadratic_bezier_point_generator_defines.svh
// ----------------------------------------------------------------------------
// Quadratic Bezier point generator: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_BEZIER_POINT_GENERATOR_DEFINES_SVH
`define QUADRATIC_BEZIER_POINT_GENERATOR_DEFINES_SVH

// same-cycle implication
`define QBPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QBPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/qbpg_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic Bezier point generator: package
// Widths, curve and step types, and the reciprocal used for the final divide.
// ----------------------------------------------------------------------------
package qbpg_pkg;

  localparam int STEPS   = 50;
  localparam int COORD_W = 16;
  localparam int IDX_W   = 6;

  localparam int SQ     = STEPS * STEPS;
  localparam int SQ_LOG = $clog2(SQ);
  localparam int W_W    = $clog2(SQ + 1);
  localparam int PROD_W = W_W + 1 + COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = $clog2(SQ * (2 ** (COORD_W - 1)) + 1);
  localparam int SH     = MAG_W + SQ_LOG;
  localparam int RECIP_W = MAG_W + 1;
  localparam int MUL_W  = MAG_W + RECIP_W;

  localparam longint unsigned RECIP_L = ((longint'(1) << SH) + longint'(SQ) - 1)
                                        / longint'(SQ);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // coordinate stages after the step register
  localparam int PIPE_D = 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [W_W-1:0]            wgt_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t cx;
    coord_t cy;
    coord_t ex;
    coord_t ey;
  } curve_t;

  typedef struct packed {
    wgt_t w0;
    wgt_t w1;
    wgt_t w2;
  } weights_t;

  typedef struct packed {
    logic vld;
    idx_t k;
    logic last;
  } ctl_t;

  typedef struct packed {
    ctl_t     ctl;
    weights_t wgt;
    curve_t   curve;
  } step_t;

endpackage

FILE: rtl/quadratic_bezier_point_generator.sv
// ----------------------------------------------------------------------------
// Quadratic Bezier point generator: top level
// Emits STEPS+1 points per curve by exact weighted sums and a reciprocal divide.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   start, ctrl, end x and y
// out      output     out_valid_o / out_stall_i point x/y, index, last flag
//
// One point per cycle unless the output stalls; a curve yields STEPS+1 = 51 points.
// The first point passes the step register and the coordinate stages. A two-curve
// queue keeps accepting until full while the sequencer works. Reset is asynchronous
// and clears only control state. An output stall freezes the whole point pipeline.
// ----------------------------------------------------------------------------
`include "quadratic_bezier_point_generator_defines.svh"

module quadratic_bezier_point_generator import qbpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] ctrl_x_i,
  input  logic signed [15:0] ctrl_y_i,
  input  logic signed [15:0] end_x_i,
  input  logic signed [15:0] end_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] point_x_o,
  output logic signed [15:0] point_y_o,
  output logic [5:0]         point_index_o,
  output logic               last_point_o
);

  curve_t in_curve;
  curve_t head;
  logic   head_valid;
  logic   pop;
  logic   en;
  step_t  step;
  ctl_t   ctl_q [PIPE_D];

  assign in_curve = '{sx: start_x_i, sy: start_y_i, cx: ctrl_x_i,
                      cy: ctrl_y_i, ex: end_x_i, ey: end_y_i};

  assign en = !(ctl_q[PIPE_D-1].vld && out_stall_i);

  qbpg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .curve_i      (in_curve),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  qbpg_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .step_o       (step)
  );

  qbpg_coord u_coord_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .wgt_i   (step.wgt),
    .p0_i    (step.curve.sx),
    .p1_i    (step.curve.cx),
    .p2_i    (step.curve.ex),
    .point_o (point_x_o)
  );

  qbpg_coord u_coord_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .wgt_i   (step.wgt),
    .p0_i    (step.curve.sy),
    .p1_i    (step.curve.cy),
    .p2_i    (step.curve.ey),
    .point_o (point_y_o)
  );

  // advance control alongside the coordinate stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_D; i++) begin
        ctl_q[i].vld <= 1'b0;
      end
    end else if (en) begin
      ctl_q[0] <= step.ctl;
      for (int i = 1; i < PIPE_D; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  assign out_valid_o   = ctl_q[PIPE_D-1].vld;
  assign point_index_o = ctl_q[PIPE_D-1].k;
  assign last_point_o  = ctl_q[PIPE_D-1].last;

  `QBPG_ASSERT_NOW(a_last_idx, out_valid_o && last_point_o,
                   point_index_o == IDX_W'(STEPS), "last point with wrong index")
  `QBPG_ASSERT_NEXT(a_pop_last, pop, step.ctl.vld && step.ctl.last,
                    "curve popped before final step")
  `QBPG_ASSERT_NOW(a_full_head, in_stall_o, head_valid, "queue full without a head curve")

endmodule

FILE: rtl/qbpg_front.sv
// ----------------------------------------------------------------------------
// Quadratic Bezier point generator: front queue
// Accepts curve transactions into a two-entry queue ahead of the sequencer.
// ----------------------------------------------------------------------------
module qbpg_front import qbpg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  curve_t curve_i,
  input  logic   pop_i,
  output logic   head_valid_o,
  output curve_t head_o
);

  curve_t     slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= curve_i;
    end
  end

endmodule

FILE: rtl/qbpg_seq.sv
// ----------------------------------------------------------------------------
// Quadratic Bezier point generator: step sequencer
// Walks k over 0..STEPS for the head curve and issues the Bernstein weights.
// ----------------------------------------------------------------------------
module qbpg_seq import qbpg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   head_valid_i,
  input  curve_t head_i,
  output logic   pop_o,
  output step_t  step_o
);

  idx_t  k_q, k_d;
  step_t step_q;
  idx_t  r;
  wgt_t  rw, kw;
  logic  at_end;

  always_comb begin
    at_end = (k_q == IDX_W'(STEPS));
    r      = IDX_W'(STEPS) - k_q;
    rw     = W_W'(r);
    kw     = W_W'(k_q);
    pop_o  = en_i && head_valid_i && at_end;
    k_d    = k_q;
    if (en_i && head_valid_i) begin
      k_d = at_end ? '0 : k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q            <= '0;
      step_q.ctl.vld <= 1'b0;
    end else begin
      k_q <= k_d;
      if (en_i) begin
        step_q.ctl.vld  <= head_valid_i;
        step_q.ctl.k    <= k_q;
        step_q.ctl.last <= at_end;
        step_q.wgt.w0   <= rw * rw;
        step_q.wgt.w1   <= (kw * rw) << 1;
        step_q.wgt.w2   <= kw * kw;
        step_q.curve    <= head_i;
      end
    end
  end

  assign step_o = step_q;

endmodule

FILE: rtl/qbpg_coord.sv
// ----------------------------------------------------------------------------
// Quadratic Bezier point generator: coordinate datapath
// Weighted sum of three control coordinates, then truncating divide by S^2.
// ----------------------------------------------------------------------------
module qbpg_coord import qbpg_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  weights_t wgt_i,
  input  coord_t   p0_i,
  input  coord_t   p1_i,
  input  coord_t   p2_i,
  output coord_t   point_o
);

  logic signed [PROD_W-1:0] prod0_q, prod1_q, prod2_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  abs_s;
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q, neg2_q;
  logic [MUL_W-1:0]         mul_q;
  logic [COORD_W-1:0]       quo;
  coord_t                   point_q;

  always_comb begin
    abs_s = sum_q[SUM_W-1] ? -sum_q : sum_q;
    quo   = mul_q[SH +: COORD_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod0_q <= $signed({1'b0, wgt_i.w0}) * p0_i;
      prod1_q <= $signed({1'b0, wgt_i.w1}) * p1_i;
      prod2_q <= $signed({1'b0, wgt_i.w2}) * p2_i;
      sum_q   <= SUM_W'(prod0_q) + SUM_W'(prod1_q) + SUM_W'(prod2_q);
      neg_q   <= sum_q[SUM_W-1];
      mag_q   <= abs_s[MAG_W-1:0];
      neg2_q  <= neg_q;
      mul_q   <= MUL_W'(mag_q) * MUL_W'(RECIP);
      point_q <= neg2_q ? coord_t'(-quo) : coord_t'(quo);
    end
  end

  assign point_o = point_q;

endmodule
